// ===== design/mpfd_pkg.sv =====
// Shared types and constants of the page-mode framebuffer draw engine.
// No dependencies; every other file of the block but mpfd_ifs.sv imports this package.
package mpfd_pkg;

	localparam int DEF_SCREEN_WIDTH = 128;
	localparam int DEF_SCREEN_PAGES = 8;
	localparam int PAGE_ROWS        = 8;
	localparam int QUEUE_DEPTH      = 4;
	localparam logic [7:0] FULL_BYTE = 8'hFF;

	localparam logic [3:0] MODE_PIX_WR   = 4'd0;
	localparam logic [3:0] MODE_PIX_RD   = 4'd1;
	localparam logic [3:0] MODE_HLINE    = 4'd2;
	localparam logic [3:0] MODE_VLINE    = 4'd3;
	localparam logic [3:0] MODE_RECT_OUT = 4'd4;
	localparam logic [3:0] MODE_RECT_FIL = 4'd5;
	localparam logic [3:0] MODE_CLEAR    = 4'd6;
	localparam logic [3:0] MODE_FILL     = 4'd7;
	localparam logic [3:0] MODE_BYTE_RD  = 4'd8;

	typedef enum logic [1:0] {
		OP_RECT,
		OP_PIX_RD,
		OP_BYTE_RD,
		OP_SWEEP
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic       ink;
		logic [7:0] x0;
		logic [7:0] x1;
		logic [7:0] y0;
		logic [7:0] y1;
		logic [9:0] baddr;
		logic       zero;
	} mpfd_op_t;

endpackage

// ===== design/mpfd_ifs.sv =====
// Valid/ready channel interfaces for draw commands and read results.
// Depends on nothing; payload widths are fixed by the command format.
interface mpfd_cmd_if;
	logic       valid;
	logic       ready;
	logic [3:0] mode;
	logic [7:0] pos_x;
	logic [7:0] pos_y;
	logic [7:0] span_w;
	logic [7:0] span_h;
	logic       ink;
	logic [9:0] byte_addr;

	modport source (output valid, mode, pos_x, pos_y, span_w, span_h, ink, byte_addr,
		input ready);
	modport sink (input valid, mode, pos_x, pos_y, span_w, span_h, ink, byte_addr,
		output ready);
endinterface

interface mpfd_rsp_if;
	logic       valid;
	logic       ready;
	logic       pixel_value;
	logic [7:0] frame_byte;

	modport source (output valid, pixel_value, frame_byte, input ready);
	modport sink (input valid, pixel_value, frame_byte, output ready);
endinterface

// ===== design/mpfd_front.sv =====
// Command front end: accepts an item, clips it and splits it into store operations.
// Depends on mpfd_pkg and mpfd_cmd_if.
module mpfd_front #(
	parameter int SCREEN_WIDTH = mpfd_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_PAGES = mpfd_pkg::DEF_SCREEN_PAGES
) (
	input  logic             clk,
	input  logic             arst_n,
	mpfd_cmd_if.sink         cmd,
	input  logic             clearing,
	output mpfd_pkg::mpfd_op_t op,
	output logic             op_valid,
	input  logic             op_ready
);
	import mpfd_pkg::*;

	localparam int SCREEN_HEIGHT = SCREEN_PAGES * PAGE_ROWS;
	localparam int STORE_BYTES   = SCREEN_WIDTH * SCREEN_PAGES;

	logic       hold_valid_q;
	logic [1:0] sub_q;
	logic [3:0] mode_q;
	logic [7:0] x_q;
	logic [7:0] y_q;
	logic [7:0] w_q;
	logic [7:0] h_q;
	logic       ink_q;
	logic [9:0] baddr_q;

	logic [7:0] sel_x;
	logic [7:0] sel_y;
	logic [7:0] sel_w;
	logic [7:0] sel_h;
	logic [8:0] x_end;
	logic [8:0] y_end;
	logic       on_x;
	logic       on_y;
	logic       clip_ok;
	logic       is_draw;
	logic       need;
	logic       last;
	logic       advance;

	always_comb begin
		sel_x   = x_q;
		sel_y   = y_q;
		sel_w   = 8'd1;
		sel_h   = 8'd1;
		is_draw = 1'b0;
		need    = 1'b0;
		op.kind = OP_RECT;
		op.ink  = ink_q;
		unique case (mode_q)
			MODE_PIX_WR: begin
				is_draw = 1'b1;
			end
			MODE_PIX_RD: begin
				op.kind = OP_PIX_RD;
				need    = 1'b1;
			end
			MODE_HLINE: begin
				is_draw = 1'b1;
				sel_w   = w_q;
			end
			MODE_VLINE: begin
				is_draw = 1'b1;
				sel_h   = h_q;
			end
			MODE_RECT_OUT: begin
				is_draw = 1'b1;
				unique case (sub_q)
					2'd0: sel_w = w_q;
					2'd1: begin
						sel_w = w_q;
						sel_y = y_q + h_q - 8'd1;
					end
					2'd2: sel_h = h_q;
					default: begin
						sel_h = h_q;
						sel_x = x_q + w_q - 8'd1;
					end
				endcase
			end
			MODE_RECT_FIL: begin
				is_draw = 1'b1;
				sel_w   = w_q;
				sel_h   = h_q;
			end
			MODE_CLEAR: begin
				op.kind = OP_SWEEP;
				op.ink  = 1'b0;
				need    = 1'b1;
			end
			MODE_FILL: begin
				op.kind = OP_SWEEP;
				op.ink  = 1'b1;
				need    = 1'b1;
			end
			MODE_BYTE_RD: begin
				op.kind = OP_BYTE_RD;
				need    = 1'b1;
			end
			default: begin
				need = 1'b0;
			end
		endcase

		on_x    = {1'b0, sel_x} < 9'(SCREEN_WIDTH);
		on_y    = {1'b0, sel_y} < 9'(SCREEN_HEIGHT);
		x_end   = {1'b0, sel_x} + {1'b0, sel_w} - 9'd1;
		y_end   = {1'b0, sel_y} + {1'b0, sel_h} - 9'd1;
		clip_ok = on_x && on_y && (sel_w != 8'd0) && (sel_h != 8'd0);

		op.x0    = sel_x;
		op.y0    = sel_y;
		op.x1    = (x_end > 9'(SCREEN_WIDTH - 1)) ? 8'(SCREEN_WIDTH - 1) : x_end[7:0];
		op.y1    = (y_end > 9'(SCREEN_HEIGHT - 1)) ? 8'(SCREEN_HEIGHT - 1) : y_end[7:0];
		op.baddr = baddr_q;
		op.zero  = (mode_q == MODE_BYTE_RD) ? (32'(baddr_q) >= 32'(STORE_BYTES))
			: !(on_x && on_y);

		op_valid = hold_valid_q && (is_draw ? clip_ok : need);
		last     = (mode_q != MODE_RECT_OUT) || (sub_q == 2'd3);
		advance  = hold_valid_q && (!op_valid || op_ready);
	end

	assign cmd.ready = !hold_valid_q && !clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			sub_q        <= 2'd0;
		end else if (cmd.valid && cmd.ready) begin
			hold_valid_q <= 1'b1;
			sub_q        <= 2'd0;
		end else if (advance) begin
			if (last) begin
				hold_valid_q <= 1'b0;
				sub_q        <= 2'd0;
			end else begin
				sub_q <= sub_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			mode_q  <= cmd.mode;
			x_q     <= cmd.pos_x;
			y_q     <= cmd.pos_y;
			w_q     <= cmd.span_w;
			h_q     <= cmd.span_h;
			ink_q   <= cmd.ink;
			baddr_q <= cmd.byte_addr;
		end
	end

endmodule

// ===== design/mpfd_queue.sv =====
// Short operation queue between the command front end and the store back end.
// Depends on mpfd_pkg for the operation type.
module mpfd_queue #(
	parameter int DEPTH = mpfd_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mpfd_pkg::mpfd_op_t push_op,
	input  logic               push_valid,
	output logic               push_ready,
	output mpfd_pkg::mpfd_op_t pop_op,
	output logic               pop_valid,
	input  logic               pop_ready
);
	import mpfd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	mpfd_op_t         slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != (PTR_W + 1)'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_op     = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

// ===== design/mpfd_back.sv =====
// Store back end: frame store memory, rectangle walker, sweeps and read results.
// Depends on mpfd_pkg and mpfd_rsp_if.
module mpfd_back #(
	parameter int SCREEN_WIDTH = mpfd_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_PAGES = mpfd_pkg::DEF_SCREEN_PAGES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mpfd_pkg::mpfd_op_t head,
	input  logic               head_valid,
	output logic               head_ready,
	output logic               clearing,
	mpfd_rsp_if.source         rsp
);
	import mpfd_pkg::*;

	localparam int STORE_BYTES = SCREEN_WIDTH * SCREEN_PAGES;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int SUM_W       = ADDR_W + 9;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_RECT   = 2'd1;
	localparam logic [1:0] ST_RESULT = 2'd2;
	localparam logic [1:0] ST_SWEEP  = 2'd3;

	logic [7:0]        store [STORE_BYTES];
	logic [7:0]        rd_q;

	logic [1:0]        state_q;
	logic              clearing_q;
	logic              ink_q;
	logic [ADDR_W-1:0] sweep_q;
	logic [ADDR_W-1:0] base_q;
	logic [7:0]        col_q;
	logic [4:0]        page_q;
	logic [7:0]        x0_q;
	logic [7:0]        x1_q;
	logic [7:0]        y0_q;
	logic [7:0]        y1_q;
	logic [2:0]        bit_q;
	logic              zero_q;
	logic              pix_mode_q;
	logic              out_valid_q;
	logic              pix_q;
	logic [7:0]        byte_q;

	logic [SUM_W-1:0]  pg_base;
	logic [SUM_W-1:0]  rd_sum;
	logic [SUM_W-1:0]  wr_sum;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wmask;
	logic [2:0]        lo_row;
	logic [2:0]        hi_row;
	logic              we;
	logic              re;
	logic              pop;
	logic              col_last;
	logic              page_last;
	logic              load_res;

	always_comb begin
		pg_base = SUM_W'(head.y0[7:3]) * SUM_W'(SCREEN_WIDTH);
		rd_sum  = pg_base + SUM_W'(head.x0);
		raddr   = (head.kind == OP_PIX_RD) ? ADDR_W'(rd_sum) : ADDR_W'(head.baddr);
		pop     = (state_q == ST_IDLE) && head_valid;
		re      = pop && ((head.kind == OP_PIX_RD) || (head.kind == OP_BYTE_RD));

		lo_row    = (page_q == y0_q[7:3]) ? y0_q[2:0] : 3'd0;
		hi_row    = (page_q == y1_q[7:3]) ? y1_q[2:0] : 3'd7;
		wr_sum    = SUM_W'(base_q) + SUM_W'(col_q);
		col_last  = col_q == x1_q;
		page_last = page_q == y1_q[7:3];

		we    = 1'b0;
		waddr = sweep_q;
		wmask = FULL_BYTE;
		if (state_q == ST_RECT) begin
			we    = 1'b1;
			waddr = ADDR_W'(wr_sum);
			wmask = (FULL_BYTE << lo_row) & (FULL_BYTE >> (3'd7 - hi_row));
		end else if (state_q == ST_SWEEP) begin
			we = 1'b1;
		end

		load_res = (state_q == ST_RESULT) && (!out_valid_q || rsp.ready);
	end

	assign head_ready      = state_q == ST_IDLE;
	assign clearing        = clearing_q;
	assign rsp.valid       = out_valid_q;
	assign rsp.pixel_value = pix_q;
	assign rsp.frame_byte  = byte_q;

	always_ff @(posedge clk) begin
		if (we) begin
			for (int i = 0; i < 8; i++) begin
				if (wmask[i]) begin
					store[waddr][i] <= ink_q;
				end
			end
		end
		if (re) begin
			rd_q <= store[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			clearing_q  <= 1'b1;
			ink_q       <= 1'b0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (head.kind)
							OP_RECT: begin
								state_q <= ST_RECT;
								ink_q   <= head.ink;
							end
							OP_SWEEP: begin
								state_q <= ST_SWEEP;
								ink_q   <= head.ink;
								sweep_q <= '0;
							end
							OP_PIX_RD: state_q <= ST_RESULT;
							OP_BYTE_RD: state_q <= ST_RESULT;
						endcase
					end
				end
				ST_RECT: begin
					if (col_last && page_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RESULT: begin
					if (load_res) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (sweep_q == ADDR_W'(STORE_BYTES - 1)) begin
						state_q    <= ST_IDLE;
						clearing_q <= 1'b0;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x0_q       <= head.x0;
			x1_q       <= head.x1;
			y0_q       <= head.y0;
			y1_q       <= head.y1;
			col_q      <= head.x0;
			page_q     <= head.y0[7:3];
			base_q     <= ADDR_W'(pg_base);
			bit_q      <= head.y0[2:0];
			zero_q     <= head.zero;
			pix_mode_q <= head.kind == OP_PIX_RD;
		end else if (state_q == ST_RECT) begin
			if (col_last) begin
				col_q  <= x0_q;
				page_q <= page_q + 5'd1;
				base_q <= ADDR_W'(SUM_W'(base_q) + SUM_W'(SCREEN_WIDTH));
			end else begin
				col_q <= col_q + 8'd1;
			end
		end
		if (load_res) begin
			pix_q  <= pix_mode_q && !zero_q && rd_q[bit_q];
			byte_q <= (pix_mode_q || zero_q) ? 8'h00 : rd_q;
		end
	end

endmodule

// ===== design/mono_page_framebuffer_draw.sv =====
// Draw engine over a page-organized monochrome framebuffer (pixel (x,y) is bit y mod 8
// of byte x + (y/8)*SCREEN_WIDTH). After reset the store is cleared by a sweep over all
// SCREEN_WIDTH*SCREEN_PAGES store bytes, during which cmd.ready stays low. The front end
// holds one item at a time, taking no new one until it has handed on all its operations,
// and splits it into clipped store operations (up to four for an outline, at most one
// otherwise); a four-entry queue feeds the back end, which writes one store byte per cycle
// while it draws or sweeps. A pixel write, line or rectangle writes each covered byte
// (columns times pages), clear and fill write every store byte, and a pixel or byte read
// holds its result in an output register until taken.
module mono_page_framebuffer_draw #(
	parameter int SCREEN_WIDTH = mpfd_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_PAGES = mpfd_pkg::DEF_SCREEN_PAGES
) (
	input  logic       clk,
	input  logic       arst_n,
	mpfd_cmd_if.sink   cmd,
	mpfd_rsp_if.source rsp
);
	import mpfd_pkg::*;

	mpfd_op_t push_op;
	mpfd_op_t head_op;
	logic     push_valid;
	logic     push_ready;
	logic     head_valid;
	logic     head_ready;
	logic     clearing;

	mpfd_front #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.SCREEN_PAGES(SCREEN_PAGES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.clearing (clearing),
		.op       (push_op),
		.op_valid (push_valid),
		.op_ready (push_ready)
	);

	mpfd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_op    (push_op),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_op     (head_op),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready)
	);

	mpfd_back #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.SCREEN_PAGES(SCREEN_PAGES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_op),
		.head_valid (head_valid),
		.head_ready (head_ready),
		.clearing   (clearing),
		.rsp        (rsp)
	);

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for mono_page_framebuffer_draw: drives draw commands, mirrors the
// frame store in a local pixel model and checks every read result against it.
// Depends on mpfd_pkg and the mpfd_cmd_if / mpfd_rsp_if channel interfaces.
module tb;
	import mpfd_pkg::*;

	localparam int SCR_W      = DEF_SCREEN_WIDTH;
	localparam int SCR_H      = DEF_SCREEN_PAGES * PAGE_ROWS;
	localparam int STORE_LEN  = DEF_SCREEN_WIDTH * DEF_SCREEN_PAGES;
	localparam int RAND_ITEMS = 1325;
	localparam int IDLE_PCT   = 32;
	localparam int CALM_LO    = 300;
	localparam int CALM_HI    = 500;
	localparam int RX_CALM_LO = 150;
	localparam int RX_CALM_HI = 250;
	localparam int HOLD_AT    = 60;
	localparam int HOLD_LEN   = 400;
	localparam int DRAIN_CYC  = 6000;
	localparam int STUCK_MAX  = 25000;

	localparam logic [3:0] MODE_SPARE_LO = 4'd9;
	localparam logic [3:0] MODE_SPARE_HI = 4'd15;

	typedef struct packed {
		logic [3:0] mode;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] w;
		logic [7:0] h;
		logic       ink;
		logic [9:0] addr;
		logic       wait_drain;
	} draw_cmd_t;

	typedef struct packed {
		logic       pix;
		logic [7:0] octet;
	} read_rsp_t;

	logic clk;
	logic arst_n;

	mpfd_cmd_if cmd_ch ();
	mpfd_rsp_if rsp_ch ();

	mono_page_framebuffer_draw dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	logic [7:0] frame_img [STORE_LEN];
	draw_cmd_t  pending [$];
	read_rsp_t  reads_due [$];
	draw_cmd_t  cur_cmd;
	int         n_sent;
	int         n_results;
	int         n_errors;
	int         n_wipes;
	int         hold_left;
	int         stuck_cycles;

	function automatic void plot(int x, int y, logic ink);
		int a;
		if (x >= SCR_W || y >= SCR_H)
			return;
		a = x + (y / PAGE_ROWS) * SCR_W;
		frame_img[a][y % PAGE_ROWS] = ink;
	endfunction

	function automatic logic peek(int x, int y);
		if (x >= SCR_W || y >= SCR_H)
			return 1'b0;
		return frame_img[x + (y / PAGE_ROWS) * SCR_W][y % PAGE_ROWS];
	endfunction

	function automatic void run_h(int x, int y, int len, logic ink);
		for (int i = 0; i < len && x + i < SCR_W; i++)
			plot(x + i, y, ink);
	endfunction

	function automatic void run_v(int x, int y, int len, logic ink);
		for (int i = 0; i < len && y + i < SCR_H; i++)
			plot(x, y + i, ink);
	endfunction

	function automatic void wipe(logic [7:0] val);
		for (int a = 0; a < STORE_LEN; a++)
			frame_img[a] = val;
		n_wipes++;
	endfunction

	function automatic void render_cmd(draw_cmd_t c);
		int x;
		int y;
		int w;
		int h;
		read_rsp_t r;
		x = c.x;
		y = c.y;
		w = c.w;
		h = c.h;
		case (c.mode)
			MODE_PIX_WR: plot(x, y, c.ink);
			MODE_PIX_RD: begin
				r.pix = peek(x, y);
				r.octet = '0;
				reads_due.push_back(r);
			end
			MODE_HLINE: run_h(x, y, w, c.ink);
			MODE_VLINE: run_v(x, y, h, c.ink);
			MODE_RECT_OUT: begin
				run_h(x, y, w, c.ink);
				run_h(x, (y + h - 1) & 255, w, c.ink);
				run_v(x, y, h, c.ink);
				run_v((x + w - 1) & 255, y, h, c.ink);
			end
			MODE_RECT_FIL: begin
				for (int j = 0; j < h && y + j < SCR_H; j++)
					run_h(x, y + j, w, c.ink);
			end
			MODE_CLEAR: wipe('0);
			MODE_FILL: wipe(FULL_BYTE);
			MODE_BYTE_RD: begin
				r.pix = 1'b0;
				r.octet = (int'(c.addr) < STORE_LEN) ? frame_img[c.addr] : '0;
				reads_due.push_back(r);
			end
			default: ;
		endcase
	endfunction

	task automatic queue_cmd(logic [3:0] mode, int x, int y, int w, int h, logic ink,
			int addr);
		draw_cmd_t c;
		c.mode = mode;
		c.x = 8'(x);
		c.y = 8'(y);
		c.w = 8'(w);
		c.h = 8'(h);
		c.ink = ink;
		c.addr = 10'(addr);
		c.wait_drain = 1'b0;
		pending.push_back(c);
	endtask

	function automatic logic [7:0] pick_coord(int span);
		if ($urandom_range(9) == 0)
			return 8'($urandom_range(255));
		return 8'($urandom_range(span - 1));
	endfunction

	function automatic logic [7:0] pick_len(int typ);
		if ($urandom_range(15) == 0)
			return 8'($urandom_range(255));
		return 8'($urandom_range(typ));
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.mode <= '0;
			cmd_ch.pos_x <= '0;
			cmd_ch.pos_y <= '0;
			cmd_ch.span_w <= '0;
			cmd_ch.span_h <= '0;
			cmd_ch.ink <= 1'b0;
			cmd_ch.byte_addr <= '0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				render_cmd(cur_cmd);
				n_sent++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (pending.size() != 0 && !(pending[0].wait_drain && reads_due.size() != 0)
						&& ((n_sent >= CALM_LO && n_sent < CALM_HI)
						|| $urandom_range(99) >= IDLE_PCT)) begin
					cur_cmd = pending.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.mode <= cur_cmd.mode;
					cmd_ch.pos_x <= cur_cmd.x;
					cmd_ch.pos_y <= cur_cmd.y;
					cmd_ch.span_w <= cur_cmd.w;
					cmd_ch.span_h <= cur_cmd.h;
					cmd_ch.ink <= cur_cmd.ink;
					cmd_ch.byte_addr <= cur_cmd.addr;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		read_rsp_t e;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_results++;
				if (reads_due.size() == 0) begin
					$error("unexpected result: pixel_value %0d frame_byte 0x%02h",
						rsp_ch.pixel_value, rsp_ch.frame_byte);
					n_errors++;
				end else begin
					e = reads_due.pop_front();
					if (rsp_ch.pixel_value !== e.pix) begin
						$error("pixel_value: expected %0d, got %0d", e.pix,
							rsp_ch.pixel_value);
						n_errors++;
					end
					if (rsp_ch.frame_byte !== e.octet) begin
						$error("frame_byte: expected 0x%02h, got 0x%02h", e.octet,
							rsp_ch.frame_byte);
						n_errors++;
					end
				end
				if (n_results == HOLD_AT)
					hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (n_results >= RX_CALM_LO && n_results < RX_CALM_HI) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_MAX) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		draw_cmd_t  c;
		logic [7:0] last_x;
		logic [7:0] last_y;
		int         roll;

		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = '0;
		cmd_ch.pos_x = '0;
		cmd_ch.pos_y = '0;
		cmd_ch.span_w = '0;
		cmd_ch.span_h = '0;
		cmd_ch.ink = 1'b0;
		cmd_ch.byte_addr = '0;
		rsp_ch.ready = 1'b0;
		n_sent = 0;
		n_results = 0;
		n_errors = 0;
		n_wipes = 0;
		stuck_cycles = 0;
		last_x = '0;
		last_y = '0;
		for (int a = 0; a < STORE_LEN; a++)
			frame_img[a] = '0;

		queue_cmd(MODE_PIX_RD, 0, 0, 0, 0, 1'b0, 0);
		queue_cmd(MODE_BYTE_RD, 0, 0, 0, 0, 1'b0, 0);
		queue_cmd(MODE_PIX_WR, 127, 63, 0, 0, 1'b1, 0);
		queue_cmd(MODE_PIX_RD, 127, 63, 0, 0, 1'b0, 0);
		queue_cmd(MODE_PIX_WR, 128, 5, 0, 0, 1'b1, 0);
		queue_cmd(MODE_PIX_WR, 255, 255, 255, 255, 1'b1, 1023);
		queue_cmd(MODE_PIX_RD, 255, 255, 0, 0, 1'b0, 0);
		queue_cmd(MODE_HLINE, 120, 10, 255, 0, 1'b1, 0);
		queue_cmd(MODE_VLINE, 3, 60, 0, 255, 1'b1, 0);
		queue_cmd(MODE_RECT_OUT, 60, 8, 5, 0, 1'b1, 0);
		queue_cmd(MODE_RECT_OUT, 200, 40, 100, 10, 1'b1, 0);
		queue_cmd(MODE_RECT_OUT, 5, 200, 10, 100, 1'b1, 0);
		queue_cmd(MODE_RECT_FIL, 30, 30, 0, 5, 1'b1, 0);
		queue_cmd(MODE_RECT_FIL, 100, 50, 255, 255, 1'b1, 0);
		queue_cmd(MODE_BYTE_RD, 0, 0, 0, 0, 1'b0, 1023);
		queue_cmd(MODE_BYTE_RD, 0, 0, 0, 0, 1'b0, 43 + 5 * SCR_W);
		queue_cmd(MODE_PIX_RD, 14, 43, 0, 0, 1'b0, 0);
		queue_cmd(MODE_SPARE_LO, 10, 10, 10, 10, 1'b1, 100);
		queue_cmd(MODE_SPARE_HI, 0, 0, 0, 0, 1'b0, 0);
		queue_cmd(MODE_FILL, 0, 0, 0, 0, 1'b1, 0);
		queue_cmd(MODE_PIX_WR, 64, 32, 0, 0, 1'b0, 0);
		queue_cmd(MODE_BYTE_RD, 0, 0, 0, 0, 1'b0, 64 + 4 * SCR_W);
		queue_cmd(MODE_CLEAR, 0, 0, 0, 0, 1'b0, 0);
		queue_cmd(MODE_BYTE_RD, 0, 0, 0, 0, 1'b0, 1023);
		queue_cmd(MODE_PIX_RD, 64, 33, 0, 0, 1'b0, 0);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			roll = $urandom_range(99);
			c.ink = 1'($urandom_range(1));
			c.addr = 10'($urandom_range(1023));
			c.x = pick_coord(SCR_W);
			c.y = pick_coord(SCR_H);
			c.w = pick_len(16);
			c.h = pick_len(16);
			if (roll < 22) begin
				c.mode = MODE_PIX_WR;
			end else if (roll < 42) begin
				c.mode = MODE_PIX_RD;
				if ($urandom_range(1) == 1) begin
					c.x = last_x;
					c.y = last_y;
				end
			end else if (roll < 52) begin
				c.mode = MODE_HLINE;
				c.w = pick_len(40);
			end else if (roll < 60) begin
				c.mode = MODE_VLINE;
				c.h = pick_len(40);
			end else if (roll < 68) begin
				c.mode = MODE_RECT_OUT;
			end else if (roll < 78) begin
				c.mode = MODE_RECT_FIL;
			end else if (roll < 96) begin
				c.mode = MODE_BYTE_RD;
				if ($urandom_range(1) == 1)
					c.addr = 10'(int'(last_x) + (int'(last_y) / PAGE_ROWS) * SCR_W);
			end else if (roll < 97) begin
				c.mode = MODE_CLEAR;
			end else if (roll < 98) begin
				c.mode = MODE_FILL;
			end else begin
				c.mode = 4'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
			end
			if (c.mode != MODE_PIX_RD && c.mode != MODE_BYTE_RD
					&& int'(c.x) < SCR_W && int'(c.y) < SCR_H) begin
				last_x = c.x;
				last_y = c.y;
			end
			c.wait_drain = (i == 0 || i == RAND_ITEMS / 2);
			pending.push_back(c);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || cmd_ch.valid)
			@(posedge clk);
		while (reads_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("Summary: %0d draw commands accepted, %0d read results checked,",
			n_sent, n_results);
		$display("         %0d whole-frame clear/fill passes, %0d mismatches.",
			n_wipes, n_errors);
		if (n_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
